[sv/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error(msg);

`endif

[sv/rsht_pkg.sv]
package rsht_pkg;

    // Default geometry of the table.
    localparam int DEF_TABLE_SLOTS = 64;
    localparam int DEF_KEY_BITS    = 32;

    // Fixed field widths on the ports.
    localparam int MODE_W     = 2;
    localparam int KEY_IN_W   = 32;
    localparam int HASH_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = KEY_IN_W + HASH_W;
    localparam int M_TDATA_W  = 16;

    // Load limit after reset.
    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 6'd48;

    // Request modes; every other code is treated as a lookup.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        CS_INIT,
        CS_IDLE,
        CS_HASH,
        CS_PROBE,
        CS_CLEAR,
        CS_HOLD
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic first_read;
        logic probe_step;
        logic sweep_step;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_clear;
        logic hash_done;
        logic stop;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

[sv/rsht_slot_mem.sv]
module rsht_slot_mem
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/rsht_hash_mod.sv]
module rsht_hash_mod
    import rsht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [HASH_W-1:0]              hash,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic [SLOT_W-1:0] home_reg;

            // A power-of-two table takes the low bits of the hash.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= hash[SLOT_W-1:0];
                end
            end

            assign done = 1'b1;
            assign home = home_reg;
        end
        else
        begin : g_reduce
            localparam int DIGITS = HASH_W / 4;
            localparam int CNT_W  = $clog2(DIGITS + 1);
            localparam int T_W    = SLOT_W + 4;
            localparam logic [T_W-1:0] DIV = T_W'(TABLE_SLOTS);

            logic [HASH_W-1:0] shift_reg;
            logic [SLOT_W-1:0] rem_reg;
            logic [SLOT_W-1:0] rem_next;
            logic [CNT_W-1:0]  cnt_reg;

            // One hex digit a cycle: the partial remainder stays below the
            // table size, so four conditional subtracts finish each step.
            always_comb
            begin
                logic [T_W-1:0] t;
                t = {rem_reg, shift_reg[HASH_W-1 -: 4]};
                for (int k = 3; k >= 0; k--)
                begin
                    if (t >= (DIV << k))
                    begin
                        t = t - (DIV << k);
                    end
                end
                rem_next = t[SLOT_W-1:0];
            end

            // Digit counter; zero means the home slot is ready.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (start)
                begin
                    cnt_reg <= CNT_W'(DIGITS);
                end
                else if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end

            // Shift the hash out most significant digit first.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shift_reg <= hash;
                    rem_reg   <= '0;
                end
                else if (cnt_reg != '0)
                begin
                    shift_reg <= shift_reg << 4;
                    rem_reg   <= rem_next;
                end
            end

            assign done = (cnt_reg == '0);
            assign home = rem_reg;
        end
    endgenerate

endmodule

[sv/rsht_datapath.sv]
module rsht_datapath
    import rsht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            stat,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic                  cfg_valid,
    input  logic [COUNT_W-1:0]    cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = KEY_BITS + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    logic [MODE_W-1:0]            mode_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [SLOT_W-1:0]            addr_reg;
    logic [SLOT_W-1:0]            probe_cnt_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_next;
    logic [COUNT_W-1:0]           max_reg;
    logic                         out_valid_reg;
    status_t                      out_status_reg;
    logic [SLOT_OUT_W-1:0]        out_slot_reg;
    logic [COUNT_W-1:0]           out_count_reg;

    logic [KEY_BITS+KEY_IN_W-1:0] key_wide;
    logic [KEY_BITS-1:0]          key_in;
    logic                         hash_done;
    logic [SLOT_W-1:0]            home;
    logic [SLOT_W-1:0]            addr_inc;
    logic                         rd_en;
    logic [SLOT_W-1:0]            rd_addr;
    logic [ENTRY_W-1:0]           rd_data;
    logic                         wr_en;
    logic [ENTRY_W-1:0]           wr_data;
    logic                         slot_empty;
    logic                         slot_hit;
    logic                         is_insert;
    logic                         is_clear;
    logic [COUNT_W:0]             count_plus;
    logic                         over_limit;
    logic                         insert_ok;
    status_t                      res_status;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;
    logic [SLOT_OUT_W-1:0]        res_slot;

    // Key compared on KEY_BITS bits.
    assign key_wide = {{KEY_BITS{1'b0}}, s_tdata[KEY_IN_W-1:0]};
    assign key_in   = key_wide[KEY_BITS-1:0];

    // Home slot from the hash.
    rsht_hash_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .hash  (s_tdata[KEY_IN_W +: HASH_W]),
        .done  (hash_done),
        .home  (home)
    );

    // Slot store: valid bit above the key.
    rsht_slot_mem #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next slot with wrap at the end of the table.
    assign addr_inc = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;

    // The read for the next slot goes out while the current one is checked.
    assign rd_en   = cmd.first_read | cmd.probe_step;
    assign rd_addr = cmd.first_read ? home : addr_inc;

    // Probe checks on the slot just read.
    assign slot_empty = ~rd_data[KEY_BITS];
    assign slot_hit   = rd_data[KEY_BITS] && (rd_data[KEY_BITS-1:0] == key_reg);

    // Result of the request.
    assign is_insert  = (mode_reg == MODE_INSERT);
    assign is_clear   = (mode_reg == MODE_CLEAR);
    assign count_plus = {1'b0, count_reg} + 1'b1;
    assign over_limit = count_plus > {1'b0, max_reg};
    assign insert_ok  = is_insert && !slot_hit && slot_empty && !over_limit;

    always_comb
    begin
        if (is_clear)
        begin
            res_status = ST_ABSENT;
            count_next = '0;
        end
        else if (is_insert)
        begin
            count_next = count_reg;
            if (slot_hit)
            begin
                res_status = ST_PRESENT;
            end
            else if (insert_ok)
            begin
                res_status = ST_INSERTED;
                count_next = count_plus[COUNT_W-1:0];
            end
            else
            begin
                res_status = ST_FULL;
            end
        end
        else
        begin
            res_status = slot_hit ? ST_FOUND : ST_ABSENT;
            count_next = count_reg;
        end
    end

    assign slot_wide = {{SLOT_OUT_W{1'b0}}, addr_reg};
    assign res_slot  = (!is_clear && (slot_hit || insert_ok)) ?
                       slot_wide[SLOT_OUT_W-1:0] : '0;

    // A sweep clears a valid bit; a successful insert stores the key.
    assign wr_en   = cmd.sweep_step | (cmd.finish & insert_ok);
    assign wr_data = cmd.sweep_step ? '0 : {1'b1, key_reg};

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tuser;
            key_reg  <= key_in;
        end
    end

    // Probe pointer, also used as the sweep pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            probe_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            addr_reg <= '0;
        end
        else if (cmd.first_read)
        begin
            addr_reg      <= home;
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_step)
        begin
            addr_reg      <= addr_inc;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        else if (cmd.sweep_step)
        begin
            addr_reg <= addr_inc;
        end
    end

    // Key count and load limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= MAX_ENTRIES_RST;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_OUT_W - COUNT_W){1'b0}}, out_count_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;

    // Status for the controller.
    assign stat.in_clear   = (s_tuser == MODE_CLEAR);
    assign stat.hash_done  = hash_done;
    assign stat.stop       = slot_empty | slot_hit | (probe_cnt_reg == LAST_SLOT);
    assign stat.sweep_last = (addr_reg == LAST_SLOT);
    assign stat.out_free   = ~out_valid_reg | m_tready;

endmodule

[sv/rsht_ctrl.sv]
module rsht_ctrl
    import rsht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CS_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_clear ? CS_CLEAR : CS_HASH;
                end
            end
            CS_HASH:
            begin
                if (stat.hash_done)
                begin
                    cmd.first_read = 1'b1;
                    state_next     = CS_PROBE;
                end
            end
            CS_PROBE:
            begin
                if (!stat.stop)
                begin
                    cmd.probe_step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
                else
                begin
                    state_next = CS_HOLD;
                end
            end
            CS_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = CS_HOLD;
                end
            end
            CS_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_INIT;
            end
        endcase
    end

endmodule

[sv/remembered_set_hash_table.sv]
// Remembered-set hash table: a fixed-size open-addressing set of object keys.
// Requests enter on the s_ stream: tuser carries the mode (lookup, insert or
// clear), tdata the key and its precomputed hash. Each request gives exactly
// one result on the m_ stream: tuser the status, tdata the slot and the count.
// The load limit is written on the cfg channel, which is always ready.
// After reset a clearing pass sweeps every slot with s_tready low.
// A lookup or insert registers its result once its probe ends, probing one
// slot a cycle through the single read port of the slot memory, and the next
// request can be taken after that; a table size that is not a power of two
// adds a digit-serial reduction of the hash. A clear request sweeps every
// slot, one a cycle, and registers its result once the sweep is done.
// One request is worked on at a time. A result waits in the output register
// while m_tready is low; the next request is accepted and probed or swept meanwhile
// and then holds until the output register is free.
module remembered_set_hash_table
    import rsht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // object_key, key_hash
    input  logic [MODE_W-1:0]    s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // slot_index, entry_count, zero pad
    output logic [STATUS_W-1:0]  m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COUNT_W-1:0]   cfg_data   // max_entries
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    rsht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[sv/rsht_checker.sv]
`include "assert_macros.svh"

module rsht_checker
    import rsht_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // A stalled result stays put.
    `ASSERT_PROP(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One request at a time: the block is busy right after an acceptance.
    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "request accepted while busy")

    // Absent and refused results carry no slot.
    `ASSERT_NEVER(a_no_slot, clk, rst_n, m_tvalid && (m_tuser == ST_ABSENT || m_tuser == ST_FULL) && m_tdata[SLOT_OUT_W-1:0] != '0, "slot given without a key")

    // A key found or held means the set is not empty.
    `ASSERT_NEVER(a_count_nonzero, clk, rst_n, m_tvalid && (m_tuser == ST_FOUND || m_tuser == ST_PRESENT || m_tuser == ST_INSERTED) && m_tdata[SLOT_OUT_W +: COUNT_W] == '0, "key reported in an empty set")

endmodule

bind remembered_set_hash_table rsht_checker u_rsht_checker (.*);
